// File: rtl/ccc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the circle contact pipeline.
package ccc_pkg;
	localparam int NORM_W    = 16;
	localparam int QUOT_W    = 15;
	localparam int NORM_FRAC = 14;
	localparam logic [QUOT_W-1:0] NORM_ONE = QUOT_W'(1 << NORM_FRAC);
endpackage

// File: rtl/ccc_front.sv
`timescale 1ns / 1ps
// Front stages: center difference, squares and overlap compare.
module ccc_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_BITS-1:0]  ax,
	input  logic signed [COORD_BITS-1:0]  ay,
	input  logic        [COORD_BITS-2:0]  ra,
	input  logic signed [COORD_BITS-1:0]  bx,
	input  logic signed [COORD_BITS-1:0]  by,
	input  logic        [COORD_BITS-2:0]  rb,
	output logic                          out_valid,
	output logic [2*COORD_BITS+1:0]       dsq,
	output logic                          hit,
	output logic                          same,
	output logic [COORD_BITS-1:0]         rsum,
	output logic [COORD_BITS:0]           adx,
	output logic [COORD_BITS:0]           ady,
	output logic                          sx,
	output logic                          sy
);
	localparam int DW = COORD_BITS + 1;
	localparam int SQW = 2 * COORD_BITS + 2;

	logic                   vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0]   dx_s1, dy_s1;
	logic [COORD_BITS-1:0]  rsum_s1, rsum_s2, rsum_s3;
	logic                   same_s1, same_s2, same_s3;
	logic signed [2*DW-1:0] dxsq_s2, dysq_s2;
	logic [2*COORD_BITS-1:0] rsq_s2;
	logic [DW-1:0]          adx_s2, ady_s2, adx_s3, ady_s3;
	logic                   sx_s2, sy_s2, sx_s3, sy_s3;
	logic [SQW-1:0]         dsq_s3;
	logic                   hit_s3;
	logic [SQW-1:0]         dsq_sum;

	assign dsq_sum = SQW'(unsigned'(dxsq_s2)) + SQW'(unsigned'(dysq_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DW'(bx) - DW'(ax);
			dy_s1   <= DW'(by) - DW'(ay);
			rsum_s1 <= COORD_BITS'(ra) + COORD_BITS'(rb);
			same_s1 <= (bx == ax) && (by == ay);

			dxsq_s2 <= dx_s1 * dx_s1;
			dysq_s2 <= dy_s1 * dy_s1;
			rsq_s2  <= (2*COORD_BITS)'(rsum_s1) * (2*COORD_BITS)'(rsum_s1);
			adx_s2  <= dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
			ady_s2  <= dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
			sx_s2   <= dx_s1[DW-1];
			sy_s2   <= dy_s1[DW-1];
			rsum_s2 <= rsum_s1;
			same_s2 <= same_s1;

			dsq_s3  <= dsq_sum;
			hit_s3  <= dsq_sum < SQW'(rsq_s2);
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			rsum_s3 <= rsum_s2;
			same_s3 <= same_s2;
		end
	end

	assign out_valid = vld_s3;
	assign dsq       = dsq_s3;
	assign hit       = hit_s3;
	assign same      = same_s3;
	assign rsum      = rsum_s3;
	assign adx       = adx_s3;
	assign ady       = ady_s3;
	assign sx        = sx_s3;
	assign sy        = sy_s3;
endmodule

// File: rtl/ccc_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module ccc_isqrt #(
	parameter int RW = 25,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int REMW = RW + 3;

	logic              vld_s  [RW+1];
	logic [REMW-1:0]   rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [2*RW-1:0]   rad_s  [RW+1];
	logic [SIDE_W-1:0] side_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = radicand;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [REMW-1:0] cur, trial;
		logic            take;

		always_comb begin
			// bring down the next two radicand bits
			cur   = {rem_s[k][REMW-3:0], rad_s[k][2*RW-1 -: 2]};
			trial = REMW'({root_s[k], 2'b01});
			take  = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? cur - trial : cur;
				root_s[k+1] <= {root_s[k][RW-2:0], take};
				rad_s[k+1]  <= {rad_s[k][2*RW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];
endmodule

// File: rtl/ccc_div.sv
`timescale 1ns / 1ps
// Pipelined two-lane restoring divider for the normal components.
module ccc_div #(
	parameter int MW = 25,
	parameter int SIDE_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [MW-1:0]                 mag_x,
	input  logic [MW-1:0]                 mag_y,
	input  logic [MW-1:0]                 divisor,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          out_valid,
	output logic [ccc_pkg::QUOT_W-1:0]    quot_x,
	output logic [ccc_pkg::QUOT_W-1:0]    quot_y,
	output logic [SIDE_W-1:0]             side_out
);
	import ccc_pkg::*;

	localparam int NW = MW + QUOT_W + 1;

	logic              vld_s  [QUOT_W+1];
	logic [NW-1:0]     remx_s [QUOT_W+1];
	logic [NW-1:0]     remy_s [QUOT_W+1];
	logic [NW-1:0]     dv_s   [QUOT_W+1];
	logic [QUOT_W-1:0] qx_s   [QUOT_W+1];
	logic [QUOT_W-1:0] qy_s   [QUOT_W+1];
	logic [SIDE_W-1:0] side_s [QUOT_W+1];

	// numerator is mag * 2^15 + root, divisor 2 * root: rounds half up
	assign vld_s[0]  = in_valid;
	assign remx_s[0] = (NW'(mag_x) << QUOT_W) + NW'(divisor);
	assign remy_s[0] = (NW'(mag_y) << QUOT_W) + NW'(divisor);
	assign dv_s[0]   = NW'(divisor) << 1;
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic [NW-1:0] shv;
		logic          tx, ty;

		always_comb begin
			shv = dv_s[k] << (QUOT_W - 1 - k);
			tx  = remx_s[k] >= shv;
			ty  = remy_s[k] >= shv;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[k+1] <= tx ? remx_s[k] - shv : remx_s[k];
				remy_s[k+1] <= ty ? remy_s[k] - shv : remy_s[k];
				qx_s[k+1]   <= {qx_s[k][QUOT_W-2:0], tx};
				qy_s[k+1]   <= {qy_s[k][QUOT_W-2:0], ty};
				dv_s[k+1]   <= dv_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QUOT_W];
	assign quot_x    = qx_s[QUOT_W];
	assign quot_y    = qy_s[QUOT_W];
	assign side_out  = side_s[QUOT_W];
endmodule

// File: rtl/circle_circle_contact_unit.sv
`timescale 1ns / 1ps
// Top level of the circle-circle contact pipeline.
// Accepts one circle pair per cycle unless stalled and returns one contact result per request, in order.
// The pipeline holds three front stages for the difference, squares and overlap compare,
// one stage per root bit of the square root (COORD_BITS + 1), fifteen divider stages for
// the normal, and the output register.
// A stall on a valid output freezes the whole pipeline and is passed back as in_stall.
module circle_circle_contact_unit #(
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         center_a_x,
	input  logic signed [COORD_BITS-1:0]         center_a_y,
	input  logic        [COORD_BITS-2:0]         radius_a,
	input  logic signed [COORD_BITS-1:0]         center_b_x,
	input  logic signed [COORD_BITS-1:0]         center_b_y,
	input  logic        [COORD_BITS-2:0]         radius_b,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic signed [ccc_pkg::NORM_W-1:0]    normal_x,
	output logic signed [ccc_pkg::NORM_W-1:0]    normal_y,
	output logic        [COORD_BITS-1:0]         depth,
	output logic                                 coincident
);
	import ccc_pkg::*;

	localparam int RW = COORD_BITS + 1;
	localparam int SQ_SIDE_W = 3 * COORD_BITS + 6;
	localparam int DV_SIDE_W = COORD_BITS + 4;

	logic                  en;
	logic                  f_vld, f_hit, f_same, f_sx, f_sy;
	logic [2*RW-1:0]       f_dsq;
	logic [COORD_BITS-1:0] f_rsum;
	logic [RW-1:0]         f_adx, f_ady;

	logic                  r_vld;
	logic [RW-1:0]         r_root;
	logic [SQ_SIDE_W-1:0]  r_side;
	logic                  r_hit, r_same, r_sx, r_sy;
	logic [COORD_BITS-1:0] r_rsum, r_depth;
	logic [RW-1:0]         r_adx, r_ady;

	logic                  d_vld;
	logic [QUOT_W-1:0]     d_qx, d_qy, d_sat_x, d_sat_y;
	logic [DV_SIDE_W-1:0]  d_side;
	logic                  d_hit, d_same, d_sx, d_sy;
	logic [COORD_BITS-1:0] d_depth;

	logic                  vld_q, hit_q, same_q;
	logic [NORM_W-1:0]     nx_q, ny_q;
	logic [COORD_BITS-1:0] depth_q;

	// advance everything unless the held result is being stalled
	assign en       = !(vld_q && out_stall);
	assign in_stall = !en;

	ccc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.ax(center_a_x), .ay(center_a_y), .ra(radius_a),
		.bx(center_b_x), .by(center_b_y), .rb(radius_b),
		.out_valid(f_vld), .dsq(f_dsq), .hit(f_hit), .same(f_same), .rsum(f_rsum),
		.adx(f_adx), .ady(f_ady), .sx(f_sx), .sy(f_sy)
	);

	ccc_isqrt #(.RW(RW), .SIDE_W(SQ_SIDE_W)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_vld), .radicand(f_dsq),
		.side_in({f_hit, f_same, f_sx, f_sy, f_rsum, f_adx, f_ady}),
		.out_valid(r_vld), .root(r_root), .side_out(r_side)
	);

	assign {r_hit, r_same, r_sx, r_sy, r_rsum, r_adx, r_ady} = r_side;
	assign r_depth = COORD_BITS'(RW'(r_rsum) - r_root);

	ccc_div #(.MW(RW), .SIDE_W(DV_SIDE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_vld),
		.mag_x(r_adx), .mag_y(r_ady), .divisor(r_root),
		.side_in({r_hit, r_same, r_sx, r_sy, r_depth}),
		.out_valid(d_vld), .quot_x(d_qx), .quot_y(d_qy), .side_out(d_side)
	);

	assign {d_hit, d_same, d_sx, d_sy, d_depth} = d_side;
	assign d_sat_x = (d_qx > NORM_ONE) ? NORM_ONE : d_qx;
	assign d_sat_y = (d_qy > NORM_ONE) ? NORM_ONE : d_qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q   <= d_hit;
			same_q  <= d_same;
			depth_q <= d_hit ? d_depth : '0;
			if (d_hit && !d_same) begin
				nx_q <= d_sx ? NORM_W'(-NORM_W'(d_sat_x)) : NORM_W'(d_sat_x);
				ny_q <= d_sy ? NORM_W'(-NORM_W'(d_sat_y)) : NORM_W'(d_sat_y);
			end else begin
				nx_q <= '0;
				ny_q <= '0;
			end
		end
	end

	assign out_valid  = vld_q;
	assign hit        = hit_q;
	assign normal_x   = signed'(nx_q);
	assign normal_y   = signed'(ny_q);
	assign depth      = depth_q;
	assign coincident = same_q;
endmodule
